### src/fdmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_pkg
// Types and constants shared by the frame difference motion centroid block.
// ----------------------------------------------------------------------------
package fdmc_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CENTER_X_W  = 10;
    localparam int CENTER_Y_W  = 11;
    localparam int AREA_OUT_W  = 22;
    localparam int COUNT_OUT_W = 22;

    localparam int THRESH_W    = 8;
    localparam int AREA_CFG_W  = 22;
    localparam int FWIDTH_W    = 11;
    localparam int FHEIGHT_W   = 12;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_AREA     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AREA     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    localparam logic [THRESH_W-1:0]   THRESHOLD_RST    = 8'd30;
    localparam logic [AREA_CFG_W-1:0] MIN_AREA_RST     = 22'd500;
    localparam logic [AREA_CFG_W-1:0] MAX_AREA_RST     = 22'd50000;
    localparam logic [FWIDTH_W-1:0]   FRAME_WIDTH_RST  = 11'd992;
    localparam logic [FHEIGHT_W-1:0]  FRAME_HEIGHT_RST = 12'd2000;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               prime;
    } t_in_item;

    typedef struct packed {
        logic                   found;
        logic [CENTER_X_W-1:0]  center_x;
        logic [CENTER_Y_W-1:0]  center_y;
        logic [AREA_OUT_W-1:0]  box_area;
        logic [COUNT_OUT_W-1:0] marked_count;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_AREA = 6'b000100,
        S_DIVX = 6'b001000,
        S_DIVY = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

endpackage

### src/frame_difference_motion_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_motion_centroid
// Frame difference motion detector: marks changed pixels against the stored
// previous frame and reports box area and centroid once per non-prime frame.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      i_in_valid/o_in_stall  i_in_item  (fdmc_pkg::t_in_item)
//  out      output     o_out_valid/i_out_stall o_out_item (fdmc_pkg::t_out_item)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  each pixel is accepted in S_IDLE, then in S_ACC the frame store read data
//  is compared and the accumulators and store are updated
//  after the last pixel of a detection frame the block runs S_AREA for the
//  area multiply, S_DIVX and S_DIVY for the two DW-bit divisions (DW = 33 at
//  default sizes) through one shared bit-serial divider and S_EMIT to load the
//  output register; o_in_stall is high all that time
//  a pending result only holds the block at a frame end, while i_out_stall
//  keeps the output register full
//  reset is synchronous active low; the frame store needs no clearing
// ----------------------------------------------------------------------------
module frame_difference_motion_centroid #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  fdmc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output fdmc_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fdmc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [fdmc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int CW1    = $clog2(MAX_WIDTH + 1);
    localparam int RW1    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AD_W   = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SX_W   = CW + CNT_W;
    localparam int SY_W   = RW + CNT_W;
    localparam int DW     = (SX_W > SY_W) ? SX_W : SY_W;
    localparam int AREA_W = CNT_W;
    localparam int CMP_W  = (AREA_W > fdmc_pkg::AREA_CFG_W) ? AREA_W : fdmc_pkg::AREA_CFG_W;

    // configuration
    logic [fdmc_pkg::THRESH_W-1:0]   r_threshold;
    logic [fdmc_pkg::AREA_CFG_W-1:0] r_min_area;
    logic [fdmc_pkg::AREA_CFG_W-1:0] r_max_area;
    logic [fdmc_pkg::FWIDTH_W-1:0]   r_frame_width;
    logic [fdmc_pkg::FHEIGHT_W-1:0]  r_frame_height;

    fdmc_pkg::t_state r_state, n_state;

    logic [fdmc_pkg::PIXEL_W-1:0] r_pix;
    logic                         r_prime;
    logic [fdmc_pkg::PIXEL_W-1:0] r_prev;
    logic [fdmc_pkg::PIXEL_W-1:0] r_frame_mem [DEPTH];

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_min_x, r_max_x;
    logic [RW-1:0]    r_min_y, r_max_y;
    logic [SX_W-1:0]  r_sum_x;
    logic [SY_W-1:0]  r_sum_y;
    logic [CNT_W-1:0] r_count;

    logic [AREA_W-1:0] r_area;
    logic [CW-1:0]     r_cx;

    fdmc_pkg::t_out_item r_out_item;
    logic                r_out_valid;

    logic [CW1-1:0]  eff_w;
    logic [RW1-1:0]  eff_h;
    logic [AD_W-1:0] addr;
    logic [fdmc_pkg::PIXEL_W-1:0] diff;
    logic            marked;
    logic            end_row;
    logic            end_frame;
    logic [CW1-1:0]  box_w;
    logic [RW1-1:0]  box_h;
    logic            div_start;
    logic            div_done;
    logic [DW-1:0]   div_dividend;
    logic [DW-1:0]   div_quotient;
    logic            out_free;
    logic            found;

    // ---------------- configuration port ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= fdmc_pkg::THRESHOLD_RST;
            r_min_area     <= fdmc_pkg::MIN_AREA_RST;
            r_max_area     <= fdmc_pkg::MAX_AREA_RST;
            r_frame_width  <= fdmc_pkg::FRAME_WIDTH_RST;
            r_frame_height <= fdmc_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fdmc_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[fdmc_pkg::THRESH_W-1:0];
                end
                fdmc_pkg::CFG_MIN_AREA: begin
                    r_min_area <= i_cfg_data[fdmc_pkg::AREA_CFG_W-1:0];
                end
                fdmc_pkg::CFG_MAX_AREA: begin
                    r_max_area <= i_cfg_data[fdmc_pkg::AREA_CFG_W-1:0];
                end
                fdmc_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[fdmc_pkg::FWIDTH_W-1:0];
                end
                fdmc_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[fdmc_pkg::FHEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // frame size clamped to 1..MAX
    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = CW1'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = CW1'(MAX_WIDTH);
        end else begin
            eff_w = CW1'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = RW1'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_h = RW1'(MAX_HEIGHT);
        end else begin
            eff_h = RW1'(r_frame_height);
        end
    end

    // ---------------- pixel path ----------------
    assign addr      = AD_W'(AD_W'(r_row) * AD_W'(MAX_WIDTH)) + AD_W'(r_col);
    assign diff      = (r_pix > r_prev) ? (r_pix - r_prev) : (r_prev - r_pix);
    assign marked    = !r_prime && (diff > r_threshold);
    assign end_row   = (CW1'(r_col) + CW1'(1)) >= eff_w;
    assign end_frame = end_row && ((RW1'(r_row) + RW1'(1)) >= eff_h);

    // store is read every cycle at the current position, written back in S_ACC
    always_ff @(posedge i_clk) begin
        if (r_state == fdmc_pkg::S_ACC) begin
            r_frame_mem[addr] <= r_pix;
        end
        r_prev <= r_frame_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pix   <= i_in_item.pixel;
            r_prime <= i_in_item.prime;
        end
    end

    // ---------------- sequencer ----------------
    assign o_in_stall = (r_state != fdmc_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdmc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fdmc_pkg::S_ACC;
            end
            fdmc_pkg::S_ACC: begin
                if (end_frame && !r_prime) n_state = fdmc_pkg::S_AREA;
                else                       n_state = fdmc_pkg::S_IDLE;
            end
            fdmc_pkg::S_AREA: begin
                n_state = fdmc_pkg::S_DIVX;
            end
            fdmc_pkg::S_DIVX: begin
                if (div_done) n_state = fdmc_pkg::S_DIVY;
            end
            fdmc_pkg::S_DIVY: begin
                if (div_done) n_state = fdmc_pkg::S_EMIT;
            end
            fdmc_pkg::S_EMIT: begin
                if (out_free) n_state = fdmc_pkg::S_IDLE;
            end
            default: begin
                n_state = fdmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdmc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- counters and accumulators ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else if (r_state == fdmc_pkg::S_ACC) begin
            if (end_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (end_row) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
            if (end_frame && r_prime) begin
                r_min_x <= '1;
                r_max_x <= '0;
                r_min_y <= '1;
                r_max_y <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else if (marked) begin
                if (r_col < r_min_x) r_min_x <= r_col;
                if (r_col > r_max_x) r_max_x <= r_col;
                if (r_row < r_min_y) r_min_y <= r_row;
                if (r_row > r_max_y) r_max_y <= r_row;
                r_sum_x <= r_sum_x + SX_W'(r_col);
                r_sum_y <= r_sum_y + SY_W'(r_row);
                r_count <= r_count + 1'b1;
            end
        end else if (r_state == fdmc_pkg::S_EMIT && out_free) begin
            // result taken into the output register, start the next frame clean
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end
    end

    // ---------------- frame end arithmetic ----------------
    assign box_w = CW1'(r_max_x) - CW1'(r_min_x) + CW1'(1);
    assign box_h = RW1'(r_max_y) - RW1'(r_min_y) + RW1'(1);

    always_ff @(posedge i_clk) begin
        if (r_state == fdmc_pkg::S_AREA) begin
            r_area <= (r_count == '0) ? '0 : AREA_W'(AREA_W'(box_w) * AREA_W'(box_h));
        end
        if (r_state == fdmc_pkg::S_DIVX && div_done) begin
            r_cx <= CW'(div_quotient);
        end
    end

    // x first, then y through the same divider
    assign div_start    = (r_state == fdmc_pkg::S_AREA) ||
                          ((r_state == fdmc_pkg::S_DIVX) && div_done);
    assign div_dividend = (r_state == fdmc_pkg::S_AREA) ? DW'(r_sum_x) : DW'(r_sum_y);

    fdmc_div #(
        .DW (DW),
        .VW (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // r_cx and r_cy hold the two quotients until the output register loads
    assign found = (r_count != '0) &&
                   (CMP_W'(r_area) > CMP_W'(r_min_area)) &&
                   (CMP_W'(r_area) < CMP_W'(r_max_area));

    logic [RW-1:0] r_cy;

    always_ff @(posedge i_clk) begin
        if (r_state == fdmc_pkg::S_DIVY && div_done) begin
            r_cy <= RW'(div_quotient);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == fdmc_pkg::S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fdmc_pkg::S_EMIT && out_free) begin
            r_out_item.found        <= found;
            r_out_item.center_x     <= (r_count == '0) ? '0 :
                                       fdmc_pkg::CENTER_X_W'(r_cx);
            r_out_item.center_y     <= (r_count == '0) ? '0 :
                                       fdmc_pkg::CENTER_Y_W'(r_cy);
            r_out_item.box_area     <= fdmc_pkg::AREA_OUT_W'(r_area);
            r_out_item.marked_count <= fdmc_pkg::COUNT_OUT_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### src/fdmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmc_div
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
module fdmc_div #(
    parameter int DW = 33,
    parameter int VW = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DW);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [VW-1:0]       r_rem;
    logic [DW-1:0]       r_q;

    logic [VW:0] shifted;
    logic [VW:0] trial;
    logic        fits;

    assign shifted = {r_rem, r_q[DW-1]};
    assign trial   = shifted - {1'b0, i_divisor};
    assign fits    = !trial[VW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
            r_q   <= {r_q[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
